/* hdl/signed_int_to_decimal_ascii_top_defines.svh */
// assertion macros for the signed integer to decimal text block
// expects i_clk and i_rst_n in the scope of each use
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// same-cycle implication
`define SITDA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SITDA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/sitda_pkg.sv */
// shared constants, types and helpers for the decimal text block
// no dependencies
package sitda_pkg;

    localparam int DIGIT_W        = 4;
    localparam int BITS_PER_STAGE = 4;

    localparam logic [7:0] ASCII_MINUS = 8'd45;
    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_NINE  = 8'd57;

    typedef logic [DIGIT_W-1:0] t_digit;

    // double dabble correction of one bcd digit
    function automatic t_digit f_add3(input t_digit d);
        t_digit r;
        r = (d >= t_digit'(5)) ? t_digit'(d + t_digit'(3)) : d;
        return r;
    endfunction

endpackage

/* hdl/sitda_if.sv */
// valid/ready channel interfaces of the decimal text block
// no dependencies
interface sitda_val_if #(
    parameter int VALUE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sitda_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

/* hdl/signed_int_to_decimal_ascii_top.sv */
// signed integer to decimal ascii text, top level
// depends on sitda_pkg, sitda_if and the defines header
//
// usage:
//   i_val  (sink)   : one transaction per signed integer, low VALUE_BITS bits used
//   o_char (source) : one transaction per character, '-' first for a negative
//                     value, then the digits most significant first with no
//                     leading zeros; last_char marks the final one
// the value passes an input stage, a double dabble pipeline of
// ceil(VALUE_BITS/4) stages (four bits each), a digit count stage and a
// serialiser that emits one character per cycle while o_char is not stalled
// into an output register; the serialiser loads the next value only after
// it has emitted every character of the last one; up to ceil(VALUE_BITS/4) + 2
// values may be in flight in the pipeline
// reset (synchronous, active low) empties the pipeline, the serialiser and
// the output register
// a stall on o_char holds the output register; the pipeline fills and then
// drops i_val.ready, nothing is lost or repeated
`include "signed_int_to_decimal_ascii_top_defines.svh"

module signed_int_to_decimal_ascii_top #(
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sitda_val_if.sink   i_val,
    sitda_char_if.source o_char
);
    import sitda_pkg::*;

    localparam int DIGITS = ((((VALUE_BITS - 1) * 1233) >>> 12) + 1);
    localparam int BCD_W  = DIGITS * DIGIT_W;
    localparam int NDS    = (VALUE_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    localparam int BIN_W  = NDS * BITS_PER_STAGE;
    localparam int CNT_W  = $clog2(DIGITS + 1);

    // dabble pipeline, stage 0 is the input stage
    logic [NDS:0]     r_vld_p;
    logic [NDS:0]     r_neg;
    logic [BCD_W-1:0] r_bcd [0:NDS];
    logic [BIN_W-1:0] r_bin [0:NDS];
    logic [BCD_W-1:0] n_bcd [0:NDS];
    logic [BIN_W-1:0] n_bin [0:NDS];

    // digit count stage
    logic             r_vld_n;
    logic             r_neg_n;
    logic [BCD_W-1:0] r_bcd_n;
    logic [CNT_W-1:0] r_nd_n;
    logic [CNT_W-1:0] n_nd;

    // serialiser and output register
    logic             r_neg_pend;
    logic [CNT_W-1:0] r_left;
    logic [BCD_W-1:0] r_dig;
    logic             r_o_vld;
    logic [7:0]       r_o_char;
    logic             r_o_last;

    logic [NDS+1:0]    w_take;
    logic [VALUE_BITS-1:0] w_raw;
    logic [VALUE_BITS-1:0] w_mag;
    logic              w_busy;
    logic              w_load;
    logic              w_adv;
    logic [CNT_W-1:0]  w_sh;

    assign w_raw = i_val.value;
    assign w_mag = w_raw[VALUE_BITS-1] ? VALUE_BITS'(~w_raw + VALUE_BITS'(1)) : w_raw;

    assign w_busy = r_neg_pend || (r_left != '0);
    assign w_load = !w_busy && r_vld_n;
    assign w_adv  = !r_o_vld || o_char.ready;
    assign w_sh   = CNT_W'(DIGITS) - r_nd_n;

    // stage hand-over, back from the serialiser
    always_comb begin
        w_take[NDS+1] = !r_vld_n || w_load;
        for (int s = NDS; s >= 0; s--) begin
            w_take[s] = !r_vld_p[s] || w_take[s+1];
        end
    end

    assign i_val.ready = w_take[0];

    // four double dabble steps per stage
    always_comb begin
        n_bcd[0] = '0;
        n_bin[0] = BIN_W'(w_mag);
        for (int s = 1; s <= NDS; s++) begin
            n_bcd[s] = r_bcd[s-1];
            n_bin[s] = r_bin[s-1];
            for (int b = 0; b < BITS_PER_STAGE; b++) begin
                for (int d = 0; d < DIGITS; d++) begin
                    n_bcd[s][d*DIGIT_W +: DIGIT_W] = f_add3(n_bcd[s][d*DIGIT_W +: DIGIT_W]);
                end
                {n_bcd[s], n_bin[s]} = {n_bcd[s], n_bin[s]} << 1;
            end
        end
    end

    // number of significant digits, at least one
    always_comb begin
        n_nd = CNT_W'(1);
        for (int d = 0; d < DIGITS; d++) begin
            if (r_bcd[NDS][d*DIGIT_W +: DIGIT_W] != '0) begin
                n_nd = CNT_W'(d + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_p <= '0;
            r_vld_n <= 1'b0;
        end else begin
            if (w_take[0]) begin
                r_vld_p[0] <= i_val.valid;
            end
            for (int s = 1; s <= NDS; s++) begin
                if (w_take[s]) begin
                    r_vld_p[s] <= r_vld_p[s-1];
                end
            end
            if (w_take[NDS+1]) begin
                r_vld_n <= r_vld_p[NDS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take[0]) begin
            r_neg[0] <= w_raw[VALUE_BITS-1];
            r_bcd[0] <= n_bcd[0];
            r_bin[0] <= n_bin[0];
        end
        for (int s = 1; s <= NDS; s++) begin
            if (w_take[s]) begin
                r_neg[s] <= r_neg[s-1];
                r_bcd[s] <= n_bcd[s];
                r_bin[s] <= n_bin[s];
            end
        end
        if (w_take[NDS+1]) begin
            r_neg_n <= r_neg[NDS];
            r_bcd_n <= r_bcd[NDS];
            r_nd_n  <= n_nd;
        end
    end

    // serialiser control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg_pend <= 1'b0;
            r_left     <= '0;
            r_o_vld    <= 1'b0;
        end else begin
            if (w_load) begin
                r_neg_pend <= r_neg_n;
                r_left     <= r_nd_n;
            end else if (w_busy && w_adv) begin
                if (r_neg_pend) begin
                    r_neg_pend <= 1'b0;
                end else begin
                    r_left <= r_left - CNT_W'(1);
                end
            end
            if (w_adv) begin
                r_o_vld <= w_busy;
            end
        end
    end

    // serialiser payload, next digit sits at the top
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_dig <= r_bcd_n << {w_sh, 2'b00};
        end else if (w_busy && w_adv && !r_neg_pend) begin
            r_dig <= r_dig << DIGIT_W;
        end
        if (w_busy && w_adv) begin
            r_o_char <= r_neg_pend ? ASCII_MINUS
                                   : ASCII_ZERO + {4'b0000, r_dig[BCD_W-1 -: DIGIT_W]};
            r_o_last <= !r_neg_pend && (r_left == CNT_W'(1));
        end
    end

    assign o_char.valid     = r_o_vld;
    assign o_char.char_code = r_o_char;
    assign o_char.last_char = r_o_last;

    `SITDA_ASSERT_IMP(a_minus_not_last, r_o_vld && (r_o_char == ASCII_MINUS), !r_o_last, "minus sign flagged as last character")
    `SITDA_ASSERT_IMP(a_char_range, r_o_vld, (r_o_char == ASCII_MINUS) || ((r_o_char >= ASCII_ZERO) && (r_o_char <= ASCII_NINE)), "character outside minus and digits")
    `SITDA_ASSERT_IMP(a_minus_has_digits, r_neg_pend, r_left != '0, "minus sign pending with no digits")
    `SITDA_ASSERT_NXT(a_count_hold, r_vld_n && !w_take[NDS+1], r_vld_n && $stable(r_nd_n), "digit count stage lost its value under stall")

endmodule
